// File: src/kod_pkg.sv
package kod_pkg;

  // Widths fixed by the register map and the result fields.
  localparam int unsigned INDEX_W      = 16;
  localparam int unsigned SPREAD_CFG_W = 16;
  localparam int unsigned MERGE_W      = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPREAD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INCREASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_INTERVAL = 2'd2;

  // Register values after reset.
  localparam logic [SPREAD_CFG_W-1:0] MIN_SPREAD_RST     = 16'd20;
  localparam logic [SPREAD_CFG_W-1:0] MIN_INCREASE_RST   = 16'd10;
  localparam logic [MERGE_W-1:0]      MERGE_INTERVAL_RST = 8'd8;

  // Default sizes handed down from the top level.
  localparam int unsigned WINDOW_LENGTH_DEF = 4;
  localparam int unsigned SAMPLE_BITS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH       = 4;

  typedef struct packed {
    logic [SPREAD_CFG_W-1:0] min_spread;
    logic [SPREAD_CFG_W-1:0] min_increase;
    logic [MERGE_W-1:0]      merge_interval;
  } kod_cfg_t;

  // Which of the two result slots carry a word this cycle.
  typedef struct packed {
    logic first;
    logic second;
  } kod_push_t;

endpackage

// File: src/kod_core.sv
module kod_core import kod_pkg::*; #(
  parameter int unsigned WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF,
  localparam int unsigned RES_W        = INDEX_W + SAMPLE_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kod_cfg_t                      cfg,
  input  logic                          go,
  input  logic signed [SAMPLE_BITS-1:0] cur,
  input  logic                          last,
  output kod_push_t                     push,
  output logic [RES_W-1:0]              res_a,
  output logic [RES_W-1:0]              res_b
);

  localparam int unsigned HIST   = WINDOW_LENGTH - 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_LENGTH);
  localparam int unsigned SPR_W  = SAMPLE_BITS + 1;
  localparam int unsigned DIFF_W = (SAMPLE_BITS + 2 > SPREAD_CFG_W + 1) ?
                                   SAMPLE_BITS + 2 : SPREAD_CFG_W + 1;

  logic signed [SAMPLE_BITS-1:0] hist [HIST];
  logic [FILL_W-1:0]             fill;
  logic [SPR_W-1:0]              prev_spread;
  logic [INDEX_W-1:0]            counter;
  logic                          pend_valid;
  logic [INDEX_W-1:0]            pend_index;
  logic signed [SAMPLE_BITS-1:0] pend_sample;

  logic signed [SAMPLE_BITS-1:0] lo, hi;
  logic signed [SPR_W-1:0]       spread_s;
  logic [SPR_W-1:0]              spread;
  logic signed [DIFF_W-1:0]      rise;
  logic                          full, hit, flush_old;
  logic [INDEX_W-1:0]            start, gap;
  logic                          pv_next;
  logic [INDEX_W-1:0]            pi_next;
  logic signed [SAMPLE_BITS-1:0] ps_next;
  logic [RES_W-1:0]              old_res, fin_res;

  always_comb begin
    lo = cur;
    hi = cur;
    for (int i = 0; i < HIST; i++) begin
      if (hist[i] < lo) lo = hist[i];
      if (hist[i] > hi) hi = hist[i];
    end
  end

  assign spread_s = SPR_W'(hi) - SPR_W'(lo);
  assign spread   = spread_s;
  assign rise     = $signed(DIFF_W'(spread)) - $signed(DIFF_W'(prev_spread));
  assign full     = (fill == FILL_W'(HIST));
  assign hit      = full && (DIFF_W'(spread) >= DIFF_W'(cfg.min_spread)) &&
                    (rise >= $signed(DIFF_W'(cfg.min_increase)));

  assign start     = counter - INDEX_W'(HIST);
  assign gap       = start - pend_index;
  // A new onset too far from the pending one pushes the pending one out.
  assign flush_old = hit && pend_valid && (gap > INDEX_W'(cfg.merge_interval));

  assign pv_next = hit || pend_valid;
  assign pi_next = hit ? start   : pend_index;
  assign ps_next = hit ? hist[0] : pend_sample;

  assign old_res = {1'b0, 1'b1, pend_sample, pend_index};
  assign fin_res = pv_next ? {1'b1, 1'b1, ps_next, pi_next} : {1'b1, (RES_W-1)'(0)};

  assign push.first  = go && (flush_old || last);
  assign push.second = go && flush_old && last;
  assign res_a       = flush_old ? old_res : fin_res;
  assign res_b       = fin_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST; i++) hist[i] <= '0;
      fill        <= '0;
      prev_spread <= '0;
      counter     <= '0;
      pend_valid  <= 1'b0;
      pend_index  <= '0;
      pend_sample <= '0;
    end else if (go) begin
      if (last) begin
        for (int i = 0; i < HIST; i++) hist[i] <= '0;
        fill        <= '0;
        prev_spread <= '0;
        counter     <= '0;
        pend_valid  <= 1'b0;
        pend_index  <= '0;
        pend_sample <= '0;
      end else begin
        for (int i = 0; i < HIST - 1; i++) hist[i] <= hist[i+1];
        hist[HIST-1] <= cur;
        if (full) prev_spread <= spread;
        else      fill        <= fill + 1'b1;
        if (counter != '1) counter <= counter + 1'b1;
        pend_valid  <= pv_next;
        pend_index  <= pi_next;
        pend_sample <= ps_next;
      end
    end
  end

endmodule

// File: src/kod_out_queue.sv
module kod_out_queue import kod_pkg::*; #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = QUEUE_DEPTH,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  kod_push_t        push,
  input  logic [WIDTH-1:0] din_a,
  input  logic [WIDTH-1:0] din_b,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] dout,
  output logic [CNT_W-1:0] level
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_b;
  logic             pop;
  logic [CNT_W-1:0] n_push;

  assign wr_ptr_b  = wr_ptr + 1'b1;
  assign out_valid = (level != '0);
  assign pop       = out_valid && out_ready;
  assign dout      = mem[rd_ptr];
  // Room for the worst case of two words from one sample.
  assign room      = (level <= CNT_W'(DEPTH - 2));
  assign n_push    = CNT_W'(push.first) + CNT_W'(push.second);

  always_ff @(posedge clk) begin
    if (push.first)  mem[wr_ptr]   <= din_a;
    if (push.second) mem[wr_ptr_b] <= din_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      level <= level + n_push - CNT_W'(pop);
    end
  end

endmodule

// File: src/knock_onset_detector.sv
// Knock onset detector.
// Samples arrive on the s_ stream, one word per sample, with s_tlast on the
// last sample of a record. Each full window of WINDOW_LENGTH samples is
// scored by its peak-to-peak spread; onsets close together merge into the
// later one. Results leave on the m_ stream: the onset's window start index
// and first sample in m_tdata, m_tuser set when an onset is carried, and
// m_tlast on the closing word of each record (an empty word if no onset).
// Throughput is one sample per cycle while at least two queue places are
// free: the spread, compares and state update fit in the single stage after
// the input register. A sample that yields two words writes both into the
// queue together. A result passes through the input register and the
// result queue before it is offered on m_tvalid.
// Results wait in a four-word queue; while fewer than two places are free
// the input register holds its sample and s_tready drops, so a stalled
// receiver never loses a word.
// Reset (rst, synchronous) empties the queue, clears the record state and
// returns the three registers to their defaults; cfg_wr_en writes a
// register at the clock edge, index 0 min_spread, 1 min_increase,
// 2 merge_interval, other indexes ignored.
module knock_onset_detector import kod_pkg::*; #(
  parameter int unsigned WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF,
  localparam int unsigned S_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned M_TDATA_W    = ((INDEX_W + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // sample
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // onset_index, onset_sample
  output logic                  m_tuser,   // onset_present
  output logic                  m_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned RES_W = INDEX_W + SAMPLE_BITS + 2;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  kod_cfg_t                      cfg;
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_last;
  logic                          go, room;
  kod_push_t                     push;
  logic [RES_W-1:0]              res_a, res_b, head;
  logic [CNT_W-1:0]              level;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_spread     <= MIN_SPREAD_RST;
      cfg.min_increase   <= MIN_INCREASE_RST;
      cfg.merge_interval <= MERGE_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_SPREAD:     cfg.min_spread     <= cfg_data;
        REG_MIN_INCREASE:   cfg.min_increase   <= cfg_data;
        REG_MERGE_INTERVAL: cfg.merge_interval <= cfg_data[MERGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign go       = in_valid && room;
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
      in_last   <= s_tlast;
    end
  end

  kod_core #(
    .WINDOW_LENGTH(WINDOW_LENGTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .go   (go),
    .cur  (in_sample),
    .last (in_last),
    .push (push),
    .res_a(res_a),
    .res_b(res_b)
  );

  kod_out_queue #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din_a    (res_a),
    .din_b    (res_b),
    .room     (room),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .dout     (head),
    .level    (level)
  );

  assign m_tdata = M_TDATA_W'(head[INDEX_W+SAMPLE_BITS-1:0]);
  assign m_tuser = head[RES_W-2];
  assign m_tlast = head[RES_W-1];

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_two_need_one: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first)
    else $error("second result slot used without the first");

  a_held_sample: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !go) |=> (in_valid && $stable(in_sample) && $stable(in_last)))
    else $error("stalled sample lost from input register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered straight after reset");
`endif

endmodule

// File: bench/tb_knock_onset_detector.sv
`timescale 1ns / 100ps

module tb_knock_onset_detector;
  import kod_pkg::*;

  localparam int HIST_LEN = WINDOW_LENGTH_DEF - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_SETTING = 280;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [15:0]        idx;
    logic signed [15:0] smp;
    logic               present;
    logic               fin;
  } onset_word_t;

  // Tracks the detector's record state and holds the words it should emit.
  class onset_scoreboard;
    logic [15:0]        min_spread;
    logic [15:0]        min_increase;
    logic [7:0]         merge_interval;
    logic signed [15:0] history [HIST_LEN];
    int                 filled;
    int                 prev_spread;
    logic [15:0]        position;
    bit                 have_pending;
    logic [15:0]        pend_index;
    logic signed [15:0] pend_sample;
    onset_word_t        expected [$];
    int                 errors;

    function new();
      min_spread = MIN_SPREAD_RST;
      min_increase = MIN_INCREASE_RST;
      merge_interval = MERGE_INTERVAL_RST;
      errors = 0;
      clear_record();
    endfunction

    function void clear_record();
      foreach (history[i]) history[i] = '0;
      filled = 0;
      prev_spread = 0;
      position = '0;
      have_pending = 0;
      pend_index = '0;
      pend_sample = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_MIN_SPREAD: min_spread = value;
        REG_MIN_INCREASE: min_increase = value;
        REG_MERGE_INTERVAL: merge_interval = value[7:0];
        default: ;
      endcase
    endfunction

    function void push_word(logic [15:0] idx, logic signed [15:0] smp, logic present,
                            logic fin);
      onset_word_t w;
      w.idx = idx;
      w.smp = smp;
      w.present = present;
      w.fin = fin;
      expected = {expected, w};
    endfunction

    function void note_sample(logic signed [15:0] smp, logic is_last);
      int          lo;
      int          hi;
      int          spread;
      logic [15:0] start;
      logic [15:0] gap;
      if (filled >= HIST_LEN) begin
        lo = smp;
        hi = smp;
        foreach (history[i]) begin
          if (history[i] < lo) lo = history[i];
          if (history[i] > hi) hi = history[i];
        end
        spread = hi - lo;
        start = position - 16'(HIST_LEN);
        if (spread >= int'(min_spread) && spread - prev_spread >= int'(min_increase)) begin
          gap = start - pend_index;
          if (have_pending && gap > 16'(merge_interval))
            push_word(pend_index, pend_sample, 1'b1, 1'b0);
          have_pending = 1;
          pend_index = start;
          pend_sample = history[0];
        end
        prev_spread = spread;
      end else begin
        filled++;
      end
      for (int i = 0; i + 1 < HIST_LEN; i++) history[i] = history[i + 1];
      history[HIST_LEN - 1] = smp;
      if (position != 16'hFFFF) position++;
      if (is_last) begin
        if (have_pending) push_word(pend_index, pend_sample, 1'b1, 1'b1);
        else push_word('0, '0, 1'b0, 1'b1);
        clear_record();
      end
    endfunction

    function void report_field(string name, int exp_v, int act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    endfunction

    function void check_word(logic [31:0] data, logic present, logic fin);
      onset_word_t w;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: word with nothing expected, expected none, actual %h user %b last %b",
                 $time, data, present, fin);
        return;
      end
      w = expected.pop_front();
      if (data[15:0] !== w.idx) report_field("onset_index", w.idx, data[15:0]);
      if ($signed(data[31:16]) !== w.smp)
        report_field("onset_sample", w.smp, $signed(data[31:16]));
      if (present !== w.present) report_field("onset_present", w.present, present);
      if (fin !== w.fin) report_field("final_res", w.fin, fin);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;   // sample
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;        // onset_index, onset_sample
  logic                  m_tuser;        // onset_present
  logic                  m_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  onset_scoreboard board = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int cycles = 0;

  knock_onset_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser, m_tlast);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("knock_onset_detector regression: fail");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_sample(input logic signed [15:0] smp, input logic is_last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tlast <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_sample(smp, is_last);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 45) v = $urandom_range(0, 40) - 20;
    else if (sel < 75) v = $urandom_range(0, 2000) - 1000;
    else if (sel < 95) v = $signed(16'($urandom));
    else begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return 16'(v);
  endfunction

  // Records follow each other with no gap beyond the random source idles; the caller drops s_tvalid when done.
  task automatic send_record(input int len);
    for (int i = 0; i < len; i++) push_sample(rand_sample(), i == len - 1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    board.write_reg(index, value);
    @(negedge clk);
  endtask

  task automatic apply_setting(input int ms, input int mi, input int mg);
    write_reg(REG_MIN_SPREAD, 16'(ms));
    write_reg(REG_MIN_INCREASE, 16'(mi));
    write_reg(REG_MERGE_INTERVAL, 16'(mg));
    cfg_wr_en <= 1'b0;
  endtask

  // A sample may still be in flight after the last expected word, hence the pause.
  task automatic wait_idle();
    @(posedge clk);
    while (board.expected.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  int set_spread [6] = '{20, 0, 65535, 300, 1000, 50};
  int set_incr   [6] = '{10, 0, 65535, 100, 0, 2000};
  int set_merge  [6] = '{8, 0, 255, 20, 255, 3};
  int set_mode   [6] = '{0, 2, 1, 3, 2, 1};
  int mode_idle  [4] = '{0, 65, 0, 6};
  int mode_stall [4] = '{0, 0, 65, 6};

  // Spikes, a merge, a separated onset and a final result carrying an onset under the reset registers.
  logic signed [15:0] directed [$] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd0, 16'sd0,
                                       16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                       16'sd500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                       16'sd0, 16'sd0, 16'sd0, -16'sd600, 16'sd1};

  initial begin
    int items;
    int len;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Record too short to fill a window.
    push_sample(16'sd32767, 1'b1);
    foreach (directed[i]) push_sample(directed[i], i == directed.size() - 1);

    for (int s = 0; s < 6; s++) begin
      if (s > 0) begin
        s_tvalid <= 1'b0;
        wait_idle();
        if (s == 3) write_reg(REG_UNUSED, 16'hFFFF);
        apply_setting(set_spread[s], set_incr[s], set_merge[s]);
      end
      src_idle_pct = mode_idle[set_mode[s]];
      sink_stall_pct = mode_stall[set_mode[s]];
      items = 0;
      while (items < ITEMS_PER_SETTING) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(41, 150);
        else len = $urandom_range(1, 40);
        send_record(len);
        items += len;
      end
    end
    s_tvalid <= 1'b0;

    wait_idle();
    if (board.errors == 0 && board.expected.size() == 0)
      $display("knock_onset_detector regression: pass");
    else
      $display("knock_onset_detector regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
src/kod_pkg.sv
src/kod_core.sv
src/kod_out_queue.sv
src/knock_onset_detector.sv
bench/tb_knock_onset_detector.sv
